### hdl/ipc_pkg.sv
// ----------------------------------------------------------------------------
// ipc_pkg
// Shared types and constants for the address text classifier: scan modes,
// verdict codes, syntax flag masks and the scan state record.
// ----------------------------------------------------------------------------
`default_nettype none

package ipc_pkg;

    // Phase of the scan through the address text.
    typedef enum logic [2:0] {
        MODE_LEAD      = 3'd0,
        MODE_V4        = 3'd1,
        MODE_V6        = 3'd2,
        MODE_V6_CLOSED = 3'd3,
        MODE_V6_PORT   = 3'd4,
        MODE_DONE      = 3'd5
    } t_mode;

    // Verdict codes; V_NONE marks that no early verdict is latched.
    typedef enum logic [2:0] {
        V_IPV4    = 3'd0,
        V_IPV6    = 3'd1,
        V_BAD4    = 3'd2,
        V_BAD6    = 3'd3,
        V_NOTADDR = 3'd4,
        V_EMPTY   = 3'd5,
        V_NONE    = 3'd7
    } t_verdict;

    // Syntax flag masks. Their meaning depends on the scan mode.
    localparam logic [4:0] FL_HEXLETTER = 5'h01;
    localparam logic [4:0] FL_BRACKET   = 5'h02;
    localparam logic [4:0] FL_PORT      = 5'h02;
    localparam logic [4:0] FL_SLASH     = 5'h04;
    localparam logic [4:0] FL_DCOLON    = 5'h08;
    localparam logic [4:0] FL_SLASHDONE = 5'h08;

    // Complete scan state carried from one byte to the next.
    typedef struct packed {
        t_mode      mode;
        logic [4:0] flags;
        logic [2:0] gdc;
        logic [2:0] gc;
        logic [1:0] colon;
        t_verdict   early;
        logic       seen;
    } t_scan_state;

    localparam t_scan_state SCAN_RESET = '{
        mode:  MODE_LEAD,
        flags: 5'd0,
        gdc:   3'd0,
        gc:    3'd0,
        colon: 2'd0,
        early: V_NONE,
        seen:  1'b0
    };

endpackage

`default_nettype wire

### hdl/ipc_step.sv
// ----------------------------------------------------------------------------
// ipc_step
// Combinational scan step: applies one text byte to the scan state and
// gives the verdict that the text would have if this byte were the last.
// ----------------------------------------------------------------------------
`default_nettype none

module ipc_step (
    input  wire logic [7:0]          i_byte,
    input  wire ipc_pkg::t_scan_state i_cur,
    output ipc_pkg::t_scan_state      o_next,
    output ipc_pkg::t_verdict         o_verdict
);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;

    ipc_pkg::t_scan_state ns;
    logic                 is_dec;
    logic                 is_hex;
    logic                 v6_bad_grp;
    logic [2:0]           gdc_w;
    logic                 dc;

    // Ends the scan with a fixed verdict; later bytes are ignored.
    function automatic ipc_pkg::t_scan_state f_latch(ipc_pkg::t_scan_state s,
                                                     ipc_pkg::t_verdict v);
        ipc_pkg::t_scan_state r;
        r       = s;
        r.mode  = ipc_pkg::MODE_DONE;
        r.early = v;
        return r;
    endfunction

    // Character classes.
    assign is_dec = i_byte inside {[8'h30:8'h39]};
    assign is_hex = i_byte inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};

    // Next scan state for this byte.
    always_comb begin
        ns    = i_cur;
        gdc_w = i_cur.gdc;
        if (i_byte != CH_NUL) begin
            ns.seen = 1'b1;
            case (i_cur.mode)
                ipc_pkg::MODE_LEAD: begin
                    if (is_hex) begin
                        if (!is_dec) begin
                            ns.flags = i_cur.flags | ipc_pkg::FL_HEXLETTER;
                        end
                        if (i_cur.gdc < 3'd7) begin
                            ns.gdc = 3'(i_cur.gdc + 3'd1);
                        end
                    end else if (i_byte == CH_DOT) begin
                        if ((|(i_cur.flags & ipc_pkg::FL_HEXLETTER)) ||
                            (i_cur.gdc > 3'd3) || (i_cur.gdc == 3'd0)) begin
                            ns = f_latch(ns, ipc_pkg::V_BAD4);
                        end else begin
                            ns.mode  = ipc_pkg::MODE_V4;
                            ns.flags = 5'd0;
                            ns.gc    = 3'(i_cur.gc + 3'd1);
                            ns.gdc   = 3'd0;
                        end
                    end else if (i_byte == CH_COLON) begin
                        if (i_cur.gdc > 3'd4) begin
                            ns = f_latch(ns, ipc_pkg::V_BAD6);
                        end else begin
                            ns.mode  = ipc_pkg::MODE_V6;
                            ns.flags = 5'd0;
                            ns.colon = 2'd1;
                        end
                    end else if (i_byte == CH_OPEN) begin
                        if ((|(i_cur.flags & ipc_pkg::FL_HEXLETTER)) ||
                            (i_cur.gdc != 3'd0)) begin
                            ns = f_latch(ns, ipc_pkg::V_NOTADDR);
                        end else begin
                            ns.mode  = ipc_pkg::MODE_V6;
                            ns.flags = ipc_pkg::FL_BRACKET;
                        end
                    end else begin
                        ns = f_latch(ns, ipc_pkg::V_NOTADDR);
                    end
                end

                ipc_pkg::MODE_V4: begin
                    if (is_dec) begin
                        // Digits count in a group or in the prefix, not in the port.
                        if ((|(i_cur.flags & ipc_pkg::FL_SLASH) &&
                             !(|(i_cur.flags & ipc_pkg::FL_SLASHDONE))) ||
                            (!(|(i_cur.flags & ipc_pkg::FL_SLASH)) &&
                             !(|(i_cur.flags & ipc_pkg::FL_PORT)))) begin
                            if (i_cur.gdc >= 3'd3) begin
                                ns = f_latch(ns, ipc_pkg::V_BAD4);
                            end else begin
                                ns.gdc = 3'(i_cur.gdc + 3'd1);
                            end
                        end
                    end else if (i_byte == CH_DOT) begin
                        if ((|(i_cur.flags & (ipc_pkg::FL_PORT | ipc_pkg::FL_SLASH))) ||
                            (i_cur.gdc == 3'd0) || (i_cur.gc >= 3'd3)) begin
                            ns = f_latch(ns, ipc_pkg::V_BAD4);
                        end else begin
                            ns.gc  = 3'(i_cur.gc + 3'd1);
                            ns.gdc = 3'd0;
                        end
                    end else if (i_byte == CH_COLON) begin
                        if ((i_cur.gc != 3'd3) || (|(i_cur.flags & ipc_pkg::FL_PORT))) begin
                            ns = f_latch(ns, ipc_pkg::V_BAD4);
                        end else if (|(i_cur.flags & ipc_pkg::FL_SLASH)) begin
                            ns.flags = i_cur.flags | ipc_pkg::FL_SLASHDONE | ipc_pkg::FL_PORT;
                        end else if (i_cur.gdc == 3'd0) begin
                            ns = f_latch(ns, ipc_pkg::V_BAD4);
                        end else begin
                            ns.flags = i_cur.flags | ipc_pkg::FL_PORT;
                        end
                    end else if (i_byte == CH_SLASH) begin
                        if ((|(i_cur.flags & ipc_pkg::FL_SLASH)) || (i_cur.gc != 3'd3) ||
                            (i_cur.gdc == 3'd0)) begin
                            ns = f_latch(ns, ipc_pkg::V_BAD4);
                        end else begin
                            ns.flags = i_cur.flags | ipc_pkg::FL_SLASH;
                            ns.gdc   = 3'd0;
                        end
                    end else begin
                        ns = f_latch(ns, ipc_pkg::V_BAD4);
                    end
                end

                ipc_pkg::MODE_V6: begin
                    if ((i_cur.colon == 2'd1) && (i_byte == CH_COLON)) begin
                        // Second colon of a double colon.
                        if (|(i_cur.flags & ipc_pkg::FL_DCOLON)) begin
                            ns = f_latch(ns, ipc_pkg::V_BAD6);
                        end else begin
                            ns.flags = i_cur.flags | ipc_pkg::FL_DCOLON;
                            ns.colon = 2'd2;
                        end
                    end else if ((i_cur.colon != 2'd0) &&
                                 (!is_hex || (i_cur.gc >= 3'd7))) begin
                        ns = f_latch(ns, ipc_pkg::V_BAD6);
                    end else begin
                        // A hex digit after a colon opens a new group.
                        if (i_cur.colon != 2'd0) begin
                            ns.gc    = 3'(i_cur.gc + 3'd1);
                            ns.colon = 2'd0;
                            gdc_w    = 3'd0;
                        end
                        if (is_hex) begin
                            if (gdc_w >= 3'd4) begin
                                ns = f_latch(ns, ipc_pkg::V_BAD6);
                            end else begin
                                ns.gdc = 3'(gdc_w + 3'd1);
                                if ((|(i_cur.flags & ipc_pkg::FL_SLASH)) &&
                                    (!is_dec || (gdc_w >= 3'd3))) begin
                                    ns = f_latch(ns, ipc_pkg::V_BAD6);
                                end
                            end
                        end else if (i_byte == CH_COLON) begin
                            if (|(i_cur.flags & ipc_pkg::FL_SLASH)) begin
                                ns = f_latch(ns, ipc_pkg::V_BAD6);
                            end else begin
                                ns.colon = 2'd1;
                            end
                        end else if (i_byte == CH_SLASH) begin
                            if (|(i_cur.flags & ipc_pkg::FL_SLASH)) begin
                                ns = f_latch(ns, ipc_pkg::V_BAD6);
                            end else begin
                                ns.flags = i_cur.flags | ipc_pkg::FL_SLASH;
                                ns.gdc   = 3'd0;
                            end
                        end else if (i_byte == CH_CLOSE) begin
                            if (!(|(i_cur.flags & ipc_pkg::FL_BRACKET))) begin
                                ns = f_latch(ns, ipc_pkg::V_BAD6);
                            end else begin
                                ns.mode = ipc_pkg::MODE_V6_CLOSED;
                            end
                        end else begin
                            ns = f_latch(ns, ipc_pkg::V_BAD6);
                        end
                    end
                end

                ipc_pkg::MODE_V6_CLOSED: begin
                    if (i_byte == CH_COLON) begin
                        ns.mode = ipc_pkg::MODE_V6_PORT;
                    end else begin
                        ns = f_latch(ns, ipc_pkg::V_BAD6);
                    end
                end

                ipc_pkg::MODE_V6_PORT: begin
                    if (!is_dec) begin
                        ns = f_latch(ns, ipc_pkg::V_BAD6);
                    end
                end

                default: begin
                end
            endcase
        end
    end

    // Group count rule for IPv6: eight groups, or fewer with one double colon.
    assign dc         = |(ns.flags & ipc_pkg::FL_DCOLON);
    assign v6_bad_grp = ((ns.gc < 3'd7) && !dc) || ((ns.gc == 3'd7) && dc);

    // Verdict if the text ends with this byte.
    always_comb begin
        case (ns.mode)
            ipc_pkg::MODE_DONE: begin
                o_verdict = ns.early;
            end
            ipc_pkg::MODE_LEAD: begin
                o_verdict = ns.seen ? ipc_pkg::V_NOTADDR : ipc_pkg::V_EMPTY;
            end
            ipc_pkg::MODE_V4: begin
                if ((ns.gc == 3'd3) &&
                    ((|(ns.flags & (ipc_pkg::FL_PORT | ipc_pkg::FL_SLASH))) ||
                     (ns.gdc != 3'd0))) begin
                    o_verdict = ipc_pkg::V_IPV4;
                end else begin
                    o_verdict = ipc_pkg::V_BAD4;
                end
            end
            ipc_pkg::MODE_V6: begin
                if ((ns.colon != 2'd0) || v6_bad_grp ||
                    (|(ns.flags & ipc_pkg::FL_BRACKET))) begin
                    o_verdict = ipc_pkg::V_BAD6;
                end else begin
                    o_verdict = ipc_pkg::V_IPV6;
                end
            end
            default: begin
                o_verdict = v6_bad_grp ? ipc_pkg::V_BAD6 : ipc_pkg::V_IPV6;
            end
        endcase
    end

    assign o_next = ns;

endmodule

`default_nettype wire

### hdl/ip_address_text_classifier.sv
// ----------------------------------------------------------------------------
// ip_address_text_classifier
// Classifies an address text streamed one byte per transaction as IPv4,
// IPv6, malformed IPv4 or IPv6, not an address, or empty.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one text byte and a last marker per transaction.
// NUL bytes are skipped. A verdict transaction leaves on the output channel
// only for a byte marked last; other bytes produce nothing.
// Each accepted byte is held in an input register and applied to the scan
// state when it leaves that register, when the verdict for a last byte is loaded
// into the output register: o_out_valid is registered behind both the input and
// the output register. One byte is taken per cycle, sustained, unless a last byte
// is held back by a stalled receiver; the scan state update lies between the registers.
// When the receiver stalls, a pending verdict stays in the output register;
// bytes that are not last keep flowing, and a last byte waits in the input
// register, which then stalls the sender until the verdict is taken.
// After each verdict the scan state returns to its reset value.
// A synchronous active-low reset clears the valid flags of both registers and
// the scan state; no transaction is lost after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module ip_address_text_classifier (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_text_byte,
    input  wire logic       i_is_last,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [2:0]      o_verdict
);

    logic                 r_in_valid;
    logic [7:0]           r_byte;
    logic                 r_last;
    logic                 r_out_valid;
    logic [2:0]           r_verdict;
    ipc_pkg::t_scan_state r_state;
    ipc_pkg::t_scan_state n_state;
    ipc_pkg::t_verdict    n_verdict;
    logic                 adv;
    logic                 in_take;

    // Scan step between the input register and the state/result registers.
    ipc_step u_step (
        .i_byte    (r_byte),
        .i_cur     (r_state),
        .o_next    (n_state),
        .o_verdict (n_verdict)
    );

    // A held byte moves on unless it needs the output register and that is blocked.
    assign adv        = r_in_valid && !(r_last && r_out_valid && i_out_stall);
    assign o_in_stall = r_in_valid && !adv;
    assign in_take    = i_in_valid && !o_in_stall;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_byte <= i_text_byte;
            r_last <= i_is_last;
        end
    end

    // Scan state; cleared after every verdict.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ipc_pkg::SCAN_RESET;
        end else if (adv) begin
            r_state <= r_last ? ipc_pkg::SCAN_RESET : n_state;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && r_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_last) begin
            r_verdict <= n_verdict;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_verdict   = r_verdict;

`ifndef SYNTH
    // The scan state is back at reset after a last byte is applied.
    a_reset_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_last |=> r_state == ipc_pkg::SCAN_RESET)
        else $error("scan state not cleared after verdict");

    // A finished scan always carries a latched verdict.
    a_done_has_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.mode == ipc_pkg::MODE_DONE |-> r_state.early != ipc_pkg::V_NONE)
        else $error("scan finished without a verdict");

    // IPv4 counters stay within their group limits.
    a_v4_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.mode == ipc_pkg::MODE_V4 |-> (r_state.gc <= 3'd3) && (r_state.gdc <= 3'd3))
        else $error("IPv4 counter out of range");

    // A byte that is not last never blocks the input channel.
    a_no_stall_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !r_last |-> !o_in_stall)
        else $error("input stalled on a byte that is not last");

    // A new verdict appears only after a last byte was applied.
    a_out_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid ##1 r_out_valid |-> $past(adv && r_last))
        else $error("verdict without a last byte");
`endif

endmodule

`default_nettype wire
